// File: src/sctr_pkg.sv
`default_nettype none
package sctr_pkg;

  // field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned SESSION_W = 4;
  localparam int unsigned RTT_W     = 16;
  localparam int unsigned WIN_W     = 11;

  // default slot count handed to the top level
  localparam int unsigned SESSIONS_DEF = 16;
  // slots that a session index can reach at all
  localparam int unsigned SESSION_REACH = 2 ** SESSION_W;

  // stream widths, packed and padded to whole bytes
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 72;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN = 2'd0,
    CMD_RTT  = 2'd1,
    CMD_ACK  = 2'd2,
    CMD_LOSS = 2'd3
  } cmd_e;

  // window limits and values written by an open
  localparam logic [WIN_W-1:0] MAX_WIN       = 11'd1024;
  localparam logic [WIN_W-1:0] MIN_SSTHRESH  = 11'd2;
  localparam logic [WIN_W-1:0] INIT_CWND     = 11'd1;
  localparam logic [WIN_W-1:0] INIT_SSTHRESH = 11'd64;
  localparam logic [RTT_W-1:0] INIT_RTT      = 16'd100;
  localparam logic [RTT_W-1:0] INIT_DEV      = 16'd50;
  localparam logic [RTT_W-1:0] INIT_MIN      = 16'd100;

  // per-slot congestion entry
  typedef struct packed {
    logic [RTT_W-1:0] rtt;
    logic [RTT_W-1:0] dev;
    logic [RTT_W-1:0] min_rtt;
    logic [WIN_W-1:0] cwnd;
    logic [WIN_W-1:0] ssthresh;
  } entry_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic             done;
    logic [WIN_W-1:0] quot;
  } div_stat_t;

endpackage
`default_nettype wire

// File: src/sctr_regfile.sv
`default_nettype none
module sctr_regfile #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  output logic                  rd_valid_o,
  output sctr_pkg::entry_t      rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire sctr_pkg::entry_t wr_data_i
);
  import sctr_pkg::*;

  entry_t            mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  entry_t            rd_data_q;
  logic              rd_valid_q;

  // slot valid bits, set by any write (only an open can create a slot)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_idx_i] <= 1'b1;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= vld_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_data_o  = rd_data_q;

endmodule
`default_nettype wire

// File: src/sctr_div.sv
`default_nettype none
module sctr_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [sctr_pkg::WIN_W-1:0]    divisor_i,
  output sctr_pkg::div_stat_t                stat_o
);
  import sctr_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIN_W + 1);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [WIN_W-1:0] rem_q;
  logic [WIN_W-1:0] dvd_q;
  logic [WIN_W-1:0] dsr_q;
  logic [WIN_W-1:0] quo_q;

  logic [WIN_W:0]   trial;
  logic             fits;
  logic [WIN_W:0]   diff;

  // one restoring step: bring down the next dividend bit and try to subtract
  always_comb begin
    trial = {rem_q, dvd_q[WIN_W-1]};
    fits  = (trial >= {1'b0, dsr_q});
    diff  = trial - {1'b0, dsr_q};
  end

  // control: step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(WIN_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: MAX_WIN divided by the window, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= MAX_WIN;
      dsr_q <= divisor_i;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
      dvd_q <= {dvd_q[WIN_W-2:0], 1'b0};
      quo_q <= {quo_q[WIN_W-2:0], fits};
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = quo_q;

endmodule
`default_nettype wire

// File: src/session_congestion_rtt_tracker_core.sv
`default_nettype none
// channel   | dir | signals                     | contents (lowest bit first)
// ----------+-----+-----------------------------+-----------------------------------------
// s_axis    | in  | tvalid tready tdata[23:0]   | cmd[1:0] session[5:2] sample[21:6]
// m_axis    | out | tvalid tready tdata[71:0]   | rtt rtt_dev min_rtt cwnd ssthresh
//           |     | tuser[0]                    | known
//
// an item passes from its transfer through the calc state, and for an ack at or above
// the slow start threshold through the divide state, where the 11-step divider for 1024/cwnd
// runs, to the done state; the next item is taken in the cycle after the result is registered
// reset clears all slot valid bits at once, so items are taken straight after reset
// a stalled result holds the output register; the following item is taken and worked on,
// and waits at its end until the register is free

module session_congestion_rtt_tracker_core #(
  parameter int unsigned SESSIONS = sctr_pkg::SESSIONS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [sctr_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // cmd, session, sample
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // rtt, rtt_dev_out, min_rtt_out, cwnd_out, ssthresh_out, zero pad
  output logic [sctr_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  output logic                                      m_axis_tuser   // known
);
  import sctr_pkg::*;

  localparam int unsigned SESS_NUM = (SESSIONS < SESSION_REACH) ? SESSIONS : SESSION_REACH;
  localparam int unsigned IDX_W    = (SESS_NUM > 1) ? $clog2(SESS_NUM) : 1;
  localparam logic [SESSION_W:0] SESS_LIM = (SESSION_W + 1)'(SESS_NUM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                state_q;
  cmd_e                  cmd_q;
  logic [SESSION_W-1:0]  session_q;
  logic [RTT_W-1:0]      sample_q;
  entry_t                res_q;
  logic                  known_q;
  logic                  wr_q;
  logic                  out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_known_q;

  logic                  in_xfer;
  logic                  out_free;
  logic [SESSION_W-1:0]  in_session;
  logic                  rd_valid;
  entry_t                rd_data;
  logic                  in_range;
  logic                  slot_ok;
  logic                  div_start;
  div_stat_t             div_stat;
  logic                  wr_en;

  // working values of the step
  logic signed [RTT_W:0] delta_s;
  logic signed [RTT_W:0] rtt_step_s;
  logic signed [RTT_W:0] rtt_sum_s;
  logic [RTT_W-1:0]      mag;
  logic signed [RTT_W:0] dev_diff_s;
  logic signed [RTT_W:0] dev_step_s;
  logic signed [RTT_W:0] dev_sum_s;
  logic [WIN_W-1:0]      half;
  logic [WIN_W:0]        ss_grow;
  logic [WIN_W-1:0]      inc;
  logic [WIN_W:0]        ca_grow;
  entry_t                calc;
  logic                  need_div;

  function automatic logic [WIN_W-1:0] cap_win(input logic [WIN_W:0] v);
    cap_win = (v > {1'b0, MAX_WIN}) ? MAX_WIN : v[WIN_W-1:0];
  endfunction

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_vld_q || m_axis_tready;
  assign in_session = s_axis_tdata[CMD_W +: SESSION_W];
  assign in_range   = ({1'b0, session_q} < SESS_LIM);
  assign slot_ok    = in_range && rd_valid;

  // slot store, read at the transfer, written when the result is registered
  sctr_regfile #(
    .DEPTH (SESS_NUM)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_xfer),
    .rd_idx_i   (in_session[IDX_W-1:0]),
    .rd_valid_o (rd_valid),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_idx_i   (session_q[IDX_W-1:0]),
    .wr_data_i  (res_q)
  );

  // shared iterative divider for the congestion avoidance increment
  sctr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (rd_data.cwnd),
    .stat_o    (div_stat)
  );

  // step arithmetic on the entry just read
  always_comb begin
    delta_s    = $signed({1'b0, sample_q}) - $signed({1'b0, rd_data.rtt});
    rtt_step_s = (delta_s + (delta_s[RTT_W] ? 17'sd7 : 17'sd0)) >>> 3;
    rtt_sum_s  = $signed({1'b0, rd_data.rtt}) + rtt_step_s;
    mag        = delta_s[RTT_W] ? RTT_W'(-delta_s) : delta_s[RTT_W-1:0];
    dev_diff_s = $signed({1'b0, mag}) - $signed({1'b0, rd_data.dev});
    dev_step_s = (dev_diff_s + (dev_diff_s[RTT_W] ? 17'sd3 : 17'sd0)) >>> 2;
    dev_sum_s  = $signed({1'b0, rd_data.dev}) + dev_step_s;
    half       = {1'b0, rd_data.cwnd[WIN_W-1:1]};
    ss_grow    = {1'b0, rd_data.cwnd} + {{WIN_W{1'b0}}, 1'b1};
    need_div   = 1'b0;
    calc       = rd_data;
    unique case (cmd_q)
      CMD_OPEN: begin
        calc.rtt      = INIT_RTT;
        calc.dev      = INIT_DEV;
        calc.min_rtt  = INIT_MIN;
        calc.cwnd     = INIT_CWND;
        calc.ssthresh = INIT_SSTHRESH;
      end
      CMD_RTT: begin
        calc.rtt = rtt_sum_s[RTT_W-1:0];
        calc.dev = dev_sum_s[RTT_W-1:0];
        if (sample_q < rd_data.min_rtt) begin
          calc.min_rtt = sample_q;
        end
      end
      CMD_ACK: begin
        if (rd_data.cwnd < rd_data.ssthresh) begin
          calc.cwnd = cap_win(ss_grow);
        end else begin
          need_div = 1'b1;
        end
      end
      CMD_LOSS: begin
        calc.ssthresh = (half < MIN_SSTHRESH) ? MIN_SSTHRESH : half;
        calc.cwnd     = INIT_CWND;
      end
      default: begin
        calc = rd_data;
      end
    endcase
  end

  // congestion avoidance growth from the quotient
  always_comb begin
    inc     = (div_stat.quot == '0) ? {{(WIN_W-1){1'b0}}, 1'b1} : div_stat.quot;
    ca_grow = {1'b0, res_q.cwnd} + {1'b0, inc};
  end

  assign div_start = (state_q == ST_CALC) && slot_ok && (cmd_q != CMD_OPEN) && need_div;
  assign wr_en     = (state_q == ST_DONE) && out_free && wr_q;

  // sequencer, step results and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_vld_q   <= 1'b0;
      wr_q        <= 1'b0;
      known_q     <= 1'b0;
      cmd_q       <= CMD_OPEN;
      session_q   <= '0;
      sample_q    <= '0;
      res_q       <= '0;
      out_data_q  <= '0;
      out_known_q <= 1'b0;
    end else begin
      if (out_vld_q && m_axis_tready && state_q != ST_DONE) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            cmd_q     <= cmd_e'(s_axis_tdata[CMD_W-1:0]);
            session_q <= in_session;
            sample_q  <= s_axis_tdata[CMD_W+SESSION_W +: RTT_W];
            state_q   <= ST_CALC;
          end
        end
        ST_CALC: begin
          res_q <= calc;
          if (in_range && cmd_q == CMD_OPEN) begin
            known_q <= 1'b1;
            wr_q    <= 1'b1;
            state_q <= ST_DONE;
          end else if (slot_ok) begin
            known_q <= 1'b1;
            wr_q    <= 1'b1;
            state_q <= need_div ? ST_DIV : ST_DONE;
          end else begin
            known_q <= 1'b0;
            wr_q    <= 1'b0;
            state_q <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            res_q.cwnd <= cap_win(ca_grow);
            state_q    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_known_q <= known_q;
            if (known_q) begin
              out_data_q <= {2'b00, res_q.ssthresh, res_q.cwnd, res_q.min_rtt,
                             res_q.dev, res_q.rtt};
            end else begin
              out_data_q <= {2'b00, {WIN_W{1'b0}}, INIT_CWND, {RTT_W{1'b0}},
                             {RTT_W{1'b0}}, INIT_RTT};
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_known_q;

`ifndef SYNTH
  // one item at a time: a transfer closes the input until the result is made
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // a known session always reports a window inside its legal range
  a_cwnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[58:48] != 11'd0 && m_axis_tdata[58:48] <= MAX_WIN))
    else $error("window out of range for a known session");

  // unknown slots report the fixed defaults
  a_unknown_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata[15:0] == INIT_RTT && m_axis_tdata[58:48] == INIT_CWND))
    else $error("unknown slot result carries wrong defaults");

  // the divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide wait");
`endif

endmodule
`default_nettype wire
